>>> src/bfro_pkg.sv
// ----------------------------------------------------------------------------
// Frame replacement order tracker package
// Operation and status codes and the command type shared by the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bfro_pkg;

    localparam int FUNC_BITS   = 2;
    localparam int PAGE_W      = 24;
    localparam int SEL_W       = 4;
    localparam int STATUS_BITS = 2;
    localparam int IDX_W       = 4;
    localparam int CFG_W       = 5;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    typedef enum logic [FUNC_BITS-1:0] {
        FUNC_INSERT    = 2'd0,
        FUNC_LOOKUP    = 2'd1,
        FUNC_TOUCH_LRU = 2'd2,
        FUNC_TOUCH_FIFO = 2'd3
    } t_func;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic accept;
        logic commit;
    } t_dp_cmd;

endpackage

`default_nettype wire

>>> src/bfro_ctrl.sv
// ----------------------------------------------------------------------------
// Frame replacement order tracker controller
// Sequences one operation at a time and owns the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module bfro_ctrl
    import bfro_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_dp_cmd   o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_UPD  = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free     = !r_out_valid || !i_stall;
    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_cmd.accept = (r_state == S_IDLE) && i_valid;
    assign o_cmd.commit = (r_state == S_UPD) && out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_stall) begin
            n_out_valid = r_out_valid;
        end else begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

>>> src/bfro_dpath.sv
// ----------------------------------------------------------------------------
// Frame replacement order tracker datapath
// Holds the page tags, both order lists, the frame count and the result.
// ----------------------------------------------------------------------------
`default_nettype none

module bfro_dpath
    import bfro_pkg::*;
#(
    parameter int NUM_FRAMES = 16,
    parameter int PAGE_BITS  = 24
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_cmd,
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_W-1:0]  i_cfg_data,
    input  wire logic [1:0]        i_func,
    input  wire logic [PAGE_W-1:0] i_page_num,
    input  wire logic [SEL_W-1:0]  i_frame_sel,
    output logic [1:0]             o_status,
    output logic                   o_found,
    output logic [IDX_W-1:0]       o_frame_index,
    output logic [IDX_W-1:0]       o_lru_oldest,
    output logic [IDX_W-1:0]       o_fifo_oldest,
    output logic [CFG_W-1:0]       o_frames_held
);

    localparam int FW = $clog2(NUM_FRAMES);
    localparam int CW = $clog2(NUM_FRAMES + 1);
    localparam int LW = (CW > CFG_W) ? CW : CFG_W;
    localparam int KW = (FW > SEL_W) ? FW : SEL_W;

    logic [PAGE_BITS-1:0] r_tag [NUM_FRAMES];
    logic [FW-1:0]        r_lru [NUM_FRAMES];
    logic [FW-1:0]        r_fifo [NUM_FRAMES];
    logic [FW-1:0]        n_lru [NUM_FRAMES];
    logic [FW-1:0]        n_fifo [NUM_FRAMES];
    logic [CW-1:0]        r_total;
    logic [CW-1:0]        n_total;
    logic [CFG_W-1:0]     r_cfg;

    t_func                r_func;
    logic [PAGE_BITS-1:0] r_page;
    logic [FW-1:0]        r_sel;
    logic [NUM_FRAMES-1:0] r_match;
    logic [NUM_FRAMES-1:0] n_match;

    logic [1:0]           r_status;
    logic                 r_found;
    logic [IDX_W-1:0]     r_fidx;
    logic [IDX_W-1:0]     r_lru_old;
    logic [IDX_W-1:0]     r_fifo_old;
    logic [CFG_W-1:0]     r_held;

    logic [31:0]          page_ext;
    logic [PAGE_BITS-1:0] page_key;
    logic [KW-1:0]        sel_key;
    t_func                in_func;
    logic [LW-1:0]        lim;
    logic [LW-1:0]        scan;
    logic                 hit;
    logic [FW-1:0]        hit_idx;
    t_status              n_status;
    logic                 n_found;
    logic [FW-1:0]        n_fidx;
    logic                 tag_we;

    assign page_ext = 32'(signed'(i_page_num));
    assign page_key = page_ext[PAGE_BITS-1:0];
    assign sel_key  = KW'(i_frame_sel);
    assign in_func  = t_func'(i_func);

    assign lim  = (r_cfg < NUM_FRAMES) ? LW'(r_cfg) : LW'(NUM_FRAMES);
    assign scan = (LW'(r_total) < lim) ? LW'(r_total) : lim;

    always_comb begin
        for (int i = 0; i < NUM_FRAMES; i++) begin
            case (in_func)
                FUNC_INSERT:    n_match[i] = 1'b0;
                FUNC_LOOKUP:    n_match[i] = (r_tag[i] == page_key);
                FUNC_TOUCH_LRU: n_match[i] = (KW'(r_lru[i]) == sel_key);
                default:        n_match[i] = (KW'(r_fifo[i]) == sel_key);
            endcase
            n_match[i] = n_match[i] && (LW'(i) < scan);
        end
    end

    always_comb begin
        hit_idx = '0;
        for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
            if (r_match[i]) begin
                hit_idx = FW'(i);
            end
        end
    end
    assign hit = |r_match;

    always_comb begin
        n_lru    = r_lru;
        n_fifo   = r_fifo;
        n_total  = r_total;
        n_status = ST_OK;
        n_found  = 1'b0;
        n_fidx   = '0;
        tag_we   = 1'b0;
        case (r_func)
            FUNC_INSERT: begin
                if (LW'(r_total) >= lim) begin
                    n_status = ST_FULL;
                end else begin
                    tag_we                    = 1'b1;
                    n_lru[r_total[FW-1:0]]    = r_total[FW-1:0];
                    n_fifo[r_total[FW-1:0]]   = r_total[FW-1:0];
                    n_fidx                    = r_total[FW-1:0];
                    n_total                   = r_total + CW'(1);
                end
            end
            FUNC_LOOKUP: begin
                n_found = hit;
                n_fidx  = hit ? hit_idx : '0;
            end
            default: begin
                if (r_total == '0) begin
                    n_status = ST_EMPTY;
                end else if (hit) begin
                    for (int j = 0; j < NUM_FRAMES; j++) begin
                        if (j < NUM_FRAMES - 1) begin
                            if (FW'(j) >= hit_idx && CW'(j + 1) < r_total) begin
                                if (r_func == FUNC_TOUCH_LRU) begin
                                    n_lru[j] = r_lru[j + 1];
                                end else begin
                                    n_fifo[j] = r_fifo[j + 1];
                                end
                            end
                        end
                        if (CW'(j + 1) == r_total) begin
                            if (r_func == FUNC_TOUCH_LRU) begin
                                n_lru[j] = r_sel;
                            end else begin
                                n_fifo[j] = r_sel;
                            end
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_cfg   <= CFG_RESET;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            if (i_cmd.commit) begin
                r_total <= n_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func  <= in_func;
            r_page  <= page_key;
            r_sel   <= FW'(i_frame_sel);
            r_match <= n_match;
        end
        if (i_cmd.commit) begin
            r_lru      <= n_lru;
            r_fifo     <= n_fifo;
            r_status   <= n_status;
            r_found    <= n_found;
            r_fidx     <= IDX_W'(n_fidx);
            r_lru_old  <= (n_total != '0) ? IDX_W'(n_lru[0]) : '0;
            r_fifo_old <= (n_total != '0) ? IDX_W'(n_fifo[0]) : '0;
            r_held     <= CFG_W'(n_total);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && tag_we) begin
            r_tag[r_total[FW-1:0]] <= r_page;
        end
    end

    assign o_status      = r_status;
    assign o_found       = r_found;
    assign o_frame_index = r_fidx;
    assign o_lru_oldest  = r_lru_old;
    assign o_fifo_oldest = r_fifo_old;
    assign o_frames_held = r_held;

endmodule

`default_nettype wire

>>> src/buffer_frame_replacement_order_top.sv
// ----------------------------------------------------------------------------
// Buffer frame replacement order tracker
// Tracks the frames of a page buffer pool in an LRU order and a FIFO order.
//
// The input channel carries an operation (insert, lookup, touch LRU, touch
// FIFO), a page number and a frame index. A transfer takes place when valid
// is high and stall is low. Each operation gives exactly one result on the
// output channel with a status, the lookup or insert frame, the oldest frame
// of each order and the frame count after the operation.
// The transfer cycle registers the parallel tag or position compare; the
// update state then updates the order lists and loads the output register
// once the output is free; the result is valid from that load on, and no
// input is taken while an operation is in the update state. The pool size
// register is written through the configuration write enable, by the user
// only while no operation is in flight; the block does not enforce this.
// Reset empties the pool and sets the pool size to sixteen frames. While the
// receiver stalls, the result holds; one more operation is accepted and held
// in the update stage, and then the input channel stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module buffer_frame_replacement_order_top
    import bfro_pkg::*;
#(
    parameter int NUM_FRAMES = 16,
    parameter int PAGE_BITS  = 24
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_W-1:0]  i_cfg_data,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [1:0]        i_func,
    input  wire logic [PAGE_W-1:0] i_page_num,
    input  wire logic [SEL_W-1:0]  i_frame_sel,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [1:0]             o_status,
    output logic                   o_found,
    output logic [IDX_W-1:0]       o_frame_index,
    output logic [IDX_W-1:0]       o_lru_oldest,
    output logic [IDX_W-1:0]       o_fifo_oldest,
    output logic [CFG_W-1:0]       o_frames_held
);

    t_dp_cmd cmd;

    bfro_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd)
    );

    bfro_dpath #(
        .NUM_FRAMES (NUM_FRAMES),
        .PAGE_BITS  (PAGE_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_func        (i_func),
        .i_page_num    (i_page_num),
        .i_frame_sel   (i_frame_sel),
        .o_status      (o_status),
        .o_found       (o_found),
        .o_frame_index (o_frame_index),
        .o_lru_oldest  (o_lru_oldest),
        .o_fifo_oldest (o_fifo_oldest),
        .o_frames_held (o_frames_held)
    );

endmodule

`default_nettype wire

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// Buffer frame replacement order tracker testbench
// Drives insert, lookup and touch operations through the valid/stall input
// channel under several pool sizes, predicts each result from an internal
// copy of the page tags and the LRU and FIFO orders, and checks every result
// transfer field by field. Both channels idle at random, and the receiver
// holds off for long stretches so that the block fills and stalls its input.
// ----------------------------------------------------------------------------
module tb;
    import bfro_pkg::*;

    localparam int LIMIT_CYCLES = 300000;
    localparam int HOLD_CYCLES  = 200;
    localparam int PHASE_ITEMS  = 315;
    localparam int POOL_MAX     = 16;

    typedef struct packed {
        t_status           status;
        logic              found;
        logic [IDX_W-1:0]  frame_index;
        logic [IDX_W-1:0]  lru_oldest;
        logic [IDX_W-1:0]  fifo_oldest;
        logic [CFG_W-1:0]  frames_held;
    } t_frame_result;

    class frame_order_scoreboard;
        logic [PAGE_W-1:0] tags [POOL_MAX];
        logic [IDX_W-1:0]  order [2][POOL_MAX];
        int unsigned       total;
        logic [CFG_W-1:0]  pool_size;
        t_frame_result     pending [$];
        int                errors;

        function new();
            total     = 0;
            pool_size = CFG_RESET;
            errors    = 0;
        endfunction

        function void set_pool_size(logic [CFG_W-1:0] value);
            pool_size = value;
        endfunction

        function int unsigned scan_limit();
            int unsigned lim;
            lim = (pool_size < POOL_MAX) ? pool_size : POOL_MAX;
            return (total < lim) ? total : lim;
        endfunction

        function t_status move_to_newest(int k, logic [IDX_W-1:0] sel);
            int pos;
            int i;
            logic [IDX_W-1:0] hit;
            if (total == 0) return ST_EMPTY;
            pos = -1;
            for (i = 0; i < int'(scan_limit()) && pos < 0; i++) begin
                if (order[k][i] == sel) pos = i;
            end
            if (pos >= 0) begin
                hit = order[k][pos];
                for (i = pos; i + 1 < int'(total); i++) order[k][i] = order[k][i + 1];
                order[k][total - 1] = hit;
            end
            return ST_OK;
        endfunction

        function void note_input(t_func op, logic [PAGE_W-1:0] page, logic [IDX_W-1:0] sel);
            t_frame_result r;
            int i;
            int unsigned lim;
            r = '0;
            r.status = ST_OK;
            case (op)
                FUNC_INSERT: begin
                    lim = (pool_size < POOL_MAX) ? pool_size : POOL_MAX;
                    if (total >= lim) begin
                        r.status = ST_FULL;
                    end else begin
                        tags[total]     = page;
                        order[0][total] = IDX_W'(total);
                        order[1][total] = IDX_W'(total);
                        r.frame_index   = IDX_W'(total);
                        total++;
                    end
                end
                FUNC_LOOKUP: begin
                    for (i = 0; i < int'(scan_limit()) && !r.found; i++) begin
                        if (tags[i] == page) begin
                            r.found       = 1'b1;
                            r.frame_index = IDX_W'(i);
                        end
                    end
                end
                FUNC_TOUCH_LRU:  r.status = move_to_newest(0, sel);
                FUNC_TOUCH_FIFO: r.status = move_to_newest(1, sel);
            endcase
            r.lru_oldest  = (total != 0) ? order[0][0] : '0;
            r.fifo_oldest = (total != 0) ? order[1][0] : '0;
            r.frames_held = CFG_W'(total);
            pending.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(t_frame_result got);
            t_frame_result want;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: result transfer with nothing expected, status %0d",
                         $time, got.status);
                return;
            end
            want = pending.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("found", want.found, got.found);
            compare_field("frame_index", want.frame_index, got.frame_index);
            compare_field("lru_oldest", want.lru_oldest, got.lru_oldest);
            compare_field("fifo_oldest", want.fifo_oldest, got.fifo_oldest);
            compare_field("frames_held", want.frames_held, got.frames_held);
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [CFG_W-1:0]  i_cfg_data = '0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [1:0]        i_func = '0;
    logic [PAGE_W-1:0] i_page_num = '0;
    logic [SEL_W-1:0]  i_frame_sel = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [1:0]        o_status;
    logic              o_found;
    logic [IDX_W-1:0]  o_frame_index;
    logic [IDX_W-1:0]  o_lru_oldest;
    logic [IDX_W-1:0]  o_fifo_oldest;
    logic [CFG_W-1:0]  o_frames_held;

    frame_order_scoreboard sb = new();

    int sender_pct = 0;
    int recv_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int cycles = 0;

    buffer_frame_replacement_order_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_func        (i_func),
        .i_page_num    (i_page_num),
        .i_frame_sel   (i_frame_sel),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_found       (o_found),
        .o_frame_index (o_frame_index),
        .o_lru_oldest  (o_lru_oldest),
        .o_fifo_oldest (o_fifo_oldest),
        .o_frames_held (o_frames_held)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_pct);
        end
    end

    always @(posedge i_clk) begin
        t_frame_result got;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                sb.note_input(t_func'(i_func), i_page_num, i_frame_sel);
            end
            if (o_valid && !i_stall) begin
                got.status      = t_status'(o_status);
                got.found       = o_found;
                got.frame_index = o_frame_index;
                got.lru_oldest  = o_lru_oldest;
                got.fifo_oldest = o_fifo_oldest;
                got.frames_held = o_frames_held;
                sb.check_result(got);
            end
        end
    end

    task automatic send_op(t_func op, logic [PAGE_W-1:0] page, logic [SEL_W-1:0] sel);
        int gap;
        i_valid     <= 1'b1;
        i_func      <= op;
        i_page_num  <= page;
        i_frame_sel <= sel;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        gap = 0;
        while ($urandom_range(0, 99) < sender_pct) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_pool_size(logic [CFG_W-1:0] value);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        sb.set_pool_size(value);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [PAGE_W-1:0] pick_page(bit from_pool);
        int r;
        r = $urandom_range(0, 99);
        if (from_pool && sb.total > 0 && r < 50) return sb.tags[$urandom_range(0, sb.total - 1)];
        r = $urandom_range(0, 99);
        if (r < 40) return PAGE_W'($urandom_range(0, 7));
        if (r < 55) return '1;
        if (r < 65) return 24'h7FFFFF;
        if (r < 72) return 24'h800000;
        return PAGE_W'($urandom);
    endfunction

    task automatic send_random_op();
        int r;
        t_func op;
        logic [PAGE_W-1:0] page;
        logic [SEL_W-1:0] sel;
        r = $urandom_range(0, 99);
        if (r < 20) op = FUNC_INSERT;
        else if (r < 55) op = FUNC_LOOKUP;
        else if (r < 77) op = FUNC_TOUCH_LRU;
        else op = FUNC_TOUCH_FIFO;
        page = pick_page(op == FUNC_LOOKUP);
        if (sb.total > 0 && $urandom_range(0, 99) < 80) sel = SEL_W'($urandom_range(0, sb.total - 1));
        else sel = SEL_W'($urandom_range(0, 15));
        send_op(op, page, sel);
    endtask

    initial begin
        int k;
        logic [CFG_W-1:0] size;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        sender_pct = 13;
        recv_pct   = 51;

        send_op(FUNC_TOUCH_LRU, 24'h000000, 4'd0);
        send_op(FUNC_TOUCH_FIFO, 24'h000000, 4'd15);
        send_op(FUNC_LOOKUP, 24'hFFFFFF, 4'd0);
        write_pool_size(5'd0);
        send_op(FUNC_INSERT, 24'h123456, 4'd0);
        send_op(FUNC_TOUCH_LRU, 24'h000000, 4'd0);
        write_pool_size(5'd3);
        send_op(FUNC_INSERT, 24'hFFFFFF, 4'd0);
        send_op(FUNC_INSERT, 24'h7FFFFF, 4'd0);
        send_op(FUNC_INSERT, 24'h000000, 4'd0);
        send_op(FUNC_INSERT, 24'h800000, 4'd0);
        send_op(FUNC_LOOKUP, 24'hFFFFFF, 4'd0);
        send_op(FUNC_LOOKUP, 24'h000000, 4'd0);
        send_op(FUNC_LOOKUP, 24'h555555, 4'd0);
        send_op(FUNC_TOUCH_LRU, 24'h000000, 4'd0);
        send_op(FUNC_TOUCH_LRU, 24'h000000, 4'd0);
        send_op(FUNC_TOUCH_FIFO, 24'h000000, 4'd1);
        send_op(FUNC_TOUCH_LRU, 24'h000000, 4'd9);
        send_op(FUNC_TOUCH_FIFO, 24'h000000, 4'd15);
        write_pool_size(5'd31);
        send_op(FUNC_INSERT, 24'h000001, 4'd0);
        send_op(FUNC_LOOKUP, 24'h000001, 4'd0);
        write_pool_size(5'd2);
        send_op(FUNC_LOOKUP, 24'h000000, 4'd0);
        send_op(FUNC_TOUCH_LRU, 24'h000000, 4'd2);
        send_op(FUNC_TOUCH_FIFO, 24'h000000, 4'd3);
        send_op(FUNC_INSERT, 24'hABCDEF, 4'd0);

        for (k = 0; k < 6; k++) begin
            case (k)
                0: size = 5'd10;
                1: size = 5'd5;
                2: size = 5'd31;
                3: size = 5'd1;
                4: size = 5'd0;
                default: size = 5'd16;
            endcase
            write_pool_size(size);
            if (k < 2) begin
                sender_pct = 13;
                recv_pct   = 51;
            end else if (k < 4) begin
                sender_pct = 51;
                recv_pct   = 13;
            end else begin
                sender_pct = 0;
                recv_pct   = 0;
            end
            if (k == 0 || k == 2) hold_requests++;
            repeat (PHASE_ITEMS) send_random_op();
        end

        wait_drained();
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
